FILE: rtl/core/text_console_writer_defines.svh
// ----------------------------------------------------------------------------
// Text console writer: assertion macros
// Shared concurrent-assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text console writer: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text console writer: assertion failed");

`endif

FILE: rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, field widths, character codes and controller types.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CNT_W   = $clog2(CELLS + 1);

    localparam int OP_W   = 2;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int POS_W  = 11;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_SET   = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        SWEEP_RESET,
        SWEEP_CLEAR,
        SWEEP_SCROLL
    } sweep_kind_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SWEEP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        capture;
        logic        exec;
        logic        read_capture;
        logic        sweep_step;
        sweep_kind_t sweep_kind;
        logic        out_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic put_scrolls;
        logic read_hit;
        logic fill_last;
        logic scroll_last;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/core/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences reset fill, request execution, cell reads, sweeps and result load.
// ----------------------------------------------------------------------------
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_INIT:
            begin
                // fill the screen with blanks of the reset attribute
                cmd.sweep_step = 1'b1;
                cmd.sweep_kind = SWEEP_RESET;
                if (status.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                case (status.op)
                    OP_PUT:   state_next = status.put_scrolls ? ST_SWEEP : ST_DONE;
                    OP_READ:  state_next = status.read_hit ? ST_READ : ST_DONE;
                    OP_SET:   state_next = ST_DONE;
                    OP_CLEAR: state_next = ST_SWEEP;
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_READ:
            begin
                cmd.read_capture = 1'b1;
                state_next       = ST_DONE;
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (status.op == OP_PUT)
                begin
                    cmd.sweep_kind = SWEEP_SCROLL;
                    if (status.scroll_last)
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    cmd.sweep_kind = SWEEP_CLEAR;
                    if (status.fill_last)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/tcw_datapath.sv
// ----------------------------------------------------------------------------
// Text console writer datapath
// Screen memory, cursor, attribute register, sweep counter and result register.
// ----------------------------------------------------------------------------
`include "text_console_writer_defines.svh"

module tcw_datapath
    import tcw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output status_t           status,
    input  logic [OP_W-1:0]   opcode,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [COL_W-1:0]  column,
    input  logic [ROW_W-1:0]  row,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ATTR_W-1:0] cfg_data,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [COL_W-1:0]  cursor_column,
    output logic [ROW_W-1:0]  cursor_row,
    output logic [POS_W-1:0]  cursor_position,
    output logic [CELL_W-1:0] cell_data,
    output logic              scrolled
);

    localparam int EPOS_W = ADDR_W + 1;

    localparam logic [COL_W:0]   COL_LIMIT   = (COL_W + 1)'(COLUMNS);
    localparam logic [ROW_W:0]   ROW_LIMIT   = (ROW_W + 1)'(ROWS);
    localparam logic [COL_W-1:0] COL_MAX     = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_MAX     = ROW_W'(ROWS - 1);
    localparam logic [CNT_W-1:0] CNT_FILL    = CNT_W'(CELLS - 1);
    localparam logic [CNT_W-1:0] CNT_SCROLL  = CNT_W'(CELLS);
    localparam logic [CNT_W-1:0] CNT_SHIFT   = CNT_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] ADDR_ROW   = ADDR_W'(COLUMNS);

    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] r,
        input logic [COL_W-1:0] c
    );
        cell_addr = ADDR_W'(r) * ADDR_ROW + ADDR_W'(c);
    endfunction

    // Request and cursor state
    op_t               op_reg;
    logic [CHAR_W-1:0] ch_reg;
    logic [COL_W-1:0]  icol_reg;
    logic [ROW_W-1:0]  irow_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ATTR_W-1:0] attr_reg;
    logic [CELL_W-1:0] data_reg;
    logic              scrolled_reg;
    logic [CNT_W-1:0]  sweep_cnt_reg;
    logic [CELL_W-1:0] rd_data_reg;

    // Result register
    logic              out_valid_reg;
    logic [COL_W-1:0]  ocol_reg;
    logic [ROW_W-1:0]  orow_reg;
    logic [POS_W-1:0]  opos_reg;
    logic [CELL_W-1:0] odata_reg;
    logic              oscr_reg;

    logic [CELL_W-1:0] screen_mem [CELLS];

    // Put character
    logic              is_nl;
    logic              is_bs;
    logic              bs_move;
    logic [COL_W:0]    put_col_step;
    logic              put_wrap;
    logic [ROW_W:0]    put_row_step;
    logic              put_scrolls;
    logic [COL_W-1:0]  put_col_next;
    logic [ROW_W-1:0]  put_row_next;
    logic              put_we;
    logic [COL_W-1:0]  put_wcol;
    logic [CELL_W-1:0] put_wdata;
    logic [CELL_W-1:0] blank_cell;

    logic              read_hit;
    logic [COL_W-1:0]  set_col;
    logic [ROW_W-1:0]  set_row;
    logic [EPOS_W-1:0] pos_full;
    logic              sweep_last;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    always_comb
    begin
        blank_cell   = {attr_reg, CH_SPACE};
        is_nl        = (ch_reg == CH_NEWLINE);
        is_bs        = (ch_reg == CH_BACKSPACE);
        bs_move      = is_bs && (col_reg != '0);
        if (is_nl)
        begin
            put_col_step = '0;
        end
        else if (is_bs)
        begin
            put_col_step = bs_move ? {1'b0, col_reg} - 1'b1 : {1'b0, col_reg};
        end
        else
        begin
            put_col_step = {1'b0, col_reg} + 1'b1;
        end
        put_wrap     = (put_col_step >= COL_LIMIT);
        put_row_step = {1'b0, row_reg} + {{ROW_W{1'b0}}, (is_nl || put_wrap)};
        put_scrolls  = (put_row_step >= ROW_LIMIT);
        put_col_next = put_wrap ? '0 : put_col_step[COL_W-1:0];
        put_row_next = put_scrolls ? ROW_MAX : put_row_step[ROW_W-1:0];
        put_we       = !is_nl && (!is_bs || bs_move);
        put_wcol     = is_bs ? col_reg - 1'b1 : col_reg;
        put_wdata    = is_bs ? blank_cell : {attr_reg, ch_reg};

        read_hit = ({1'b0, icol_reg} < COL_LIMIT) && ({1'b0, irow_reg} < ROW_LIMIT);
        set_col  = ({1'b0, icol_reg} < COL_LIMIT) ? icol_reg : COL_MAX;
        set_row  = ({1'b0, irow_reg} < ROW_LIMIT) ? irow_reg : ROW_MAX;

        pos_full = EPOS_W'(row_reg) * EPOS_W'(COLUMNS) + EPOS_W'(col_reg);
    end

    // Memory port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        if (cmd.exec)
        begin
            case (op_reg)
                OP_PUT:
                begin
                    mem_we    = put_we;
                    mem_waddr = cell_addr(row_reg, put_wcol);
                    mem_wdata = put_wdata;
                end
                OP_READ:
                begin
                    mem_re    = read_hit;
                    mem_raddr = cell_addr(irow_reg, icol_reg);
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
        if (cmd.sweep_step)
        begin
            case (cmd.sweep_kind)
                SWEEP_SCROLL:
                begin
                    // read one row ahead, write the previous step's data a row up
                    mem_re    = (sweep_cnt_reg < CNT_SHIFT);
                    mem_raddr = ADDR_W'(sweep_cnt_reg) + ADDR_ROW;
                    mem_we    = (sweep_cnt_reg != '0);
                    mem_waddr = ADDR_W'(sweep_cnt_reg - 1'b1);
                    mem_wdata = (sweep_cnt_reg <= CNT_SHIFT) ? rd_data_reg : blank_cell;
                end
                SWEEP_CLEAR:
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(sweep_cnt_reg);
                    mem_wdata = blank_cell;
                end
                SWEEP_RESET:
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ADDR_W'(sweep_cnt_reg);
                    mem_wdata = {ATTR_RESET, CH_SPACE};
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= screen_mem[mem_raddr];
        end
    end

    assign sweep_last = (cmd.sweep_kind == SWEEP_SCROLL) ? (sweep_cnt_reg == CNT_SCROLL)
                                                         : (sweep_cnt_reg == CNT_FILL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= OP_PUT;
            col_reg       <= '0;
            row_reg       <= '0;
            attr_reg      <= ATTR_RESET;
            data_reg      <= '0;
            scrolled_reg  <= 1'b0;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                attr_reg <= cfg_data;
            end
            if (cmd.capture)
            begin
                op_reg       <= op_t'(opcode);
                data_reg     <= '0;
                scrolled_reg <= 1'b0;
            end
            if (cmd.read_capture)
            begin
                data_reg <= rd_data_reg;
            end
            if (cmd.exec)
            begin
                case (op_reg)
                    OP_PUT:
                    begin
                        col_reg      <= put_col_next;
                        row_reg      <= put_row_next;
                        scrolled_reg <= put_scrolls;
                    end
                    OP_SET:
                    begin
                        col_reg <= set_col;
                        row_reg <= set_row;
                    end
                    OP_CLEAR:
                    begin
                        col_reg <= '0;
                        row_reg <= '0;
                    end
                    default:
                    begin
                        col_reg <= col_reg;
                    end
                endcase
            end
            if (cmd.sweep_step)
            begin
                sweep_cnt_reg <= sweep_last ? '0 : sweep_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg   <= char_code;
            icol_reg <= column;
            irow_reg <= row;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            ocol_reg  <= col_reg;
            orow_reg  <= row_reg;
            opos_reg  <= pos_full[POS_W-1:0];
            odata_reg <= data_reg;
            oscr_reg  <= scrolled_reg;
        end
    end

    assign status.op          = op_reg;
    assign status.put_scrolls = put_scrolls;
    assign status.read_hit    = read_hit;
    assign status.fill_last   = (sweep_cnt_reg == CNT_FILL);
    assign status.scroll_last = (sweep_cnt_reg == CNT_SCROLL);
    assign status.out_free    = !out_valid_reg || !out_stall;

    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign cursor_column   = ocol_reg;
    assign cursor_row      = orow_reg;
    assign cursor_position = opos_reg;
    assign cell_data       = odata_reg;
    assign scrolled        = oscr_reg;

    `TCW_ASSERT_NOW(a_cursor_in_screen, 1'b1, ({1'b0, col_reg} < COL_LIMIT) && ({1'b0, row_reg} < ROW_LIMIT))
    `TCW_ASSERT_NOW(a_sweep_cnt_idle, !cmd.sweep_step, sweep_cnt_reg == '0)
    `TCW_ASSERT_NOW(a_data_only_on_read, data_reg != '0, op_reg == OP_READ)
    `TCW_ASSERT_NEXT(a_load_shows_result, cmd.out_load, out_valid_reg)

endmodule

FILE: rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// Text-mode console over an 80 by 25 screen memory of attribute/character cells.
// ----------------------------------------------------------------------------
// After reset the block fills the screen, one cell a cycle, with blanks of
// attribute 7 and accepts no request until done; attribute writes are taken at
// any time. A put character, read outside the screen or set cursor request goes
// through accept, execute and load; a read cell puts a registered memory read
// between execute and load. A put that scrolls and a clear screen add a sweep
// that walks the screen memory one cell per cycle. One request is in flight at a
// time; the result register lets the next request be accepted while a result
// waits.
module text_console_writer
    import tcw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   opcode,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [COL_W-1:0]  column,
    input  logic [ROW_W-1:0]  row,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ATTR_W-1:0] cfg_data,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [COL_W-1:0]  cursor_column,
    output logic [ROW_W-1:0]  cursor_row,
    output logic [POS_W-1:0]  cursor_position,
    output logic [CELL_W-1:0] cell_data,
    output logic              scrolled
);

    cmd_t    cmd;
    status_t status;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tcw_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .opcode          (opcode),
        .char_code       (char_code),
        .column          (column),
        .row             (row),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cursor_column   (cursor_column),
        .cursor_row      (cursor_row),
        .cursor_position (cursor_position),
        .cell_data       (cell_data),
        .scrolled        (scrolled)
    );

endmodule

FILE: tb/text_console_writer_test.sv
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put, read, set-cursor and clear requests into the console engine
// and checks every result against a cycle-free model of the screen memory
// and cursor. Directed cases cover the edges of the screen, then random
// traffic runs under several sender and receiver idling patterns, with the
// text attribute rewritten between phases.
// ----------------------------------------------------------------------------
module text_console_writer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
    } console_request_t;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [POS_W-1:0]  position;
        logic [CELL_W-1:0] cell_value;
        logic              scrolled;
    } console_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [OP_W-1:0]   opcode = '0;
    logic [CHAR_W-1:0] char_code = '0;
    logic [COL_W-1:0]  column = '0;
    logic [ROW_W-1:0]  row = '0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [ATTR_W-1:0] cfg_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;

    // Model of the console
    logic [CELL_W-1:0] screen_model [CELLS];
    int                cursor_col_model = 0;
    int                cursor_row_model = 0;
    logic [ATTR_W-1:0] text_attr = ATTR_RESET;

    console_result_t   expected_results [$];
    int                mismatches = 0;
    int                idle_pct = 0;
    int                stall_pct = 0;
    int                idle_cycles = 0;

    text_console_writer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .char_code      (char_code),
        .column         (column),
        .row            (row),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cursor_column  (cursor_column),
        .cursor_row     (cursor_row),
        .cursor_position(cursor_position),
        .cell_data      (cell_data),
        .scrolled       (scrolled)
    );

    always #5 clk = ~clk;

    function automatic console_request_t make_request(input op_t op,
                                                      input logic [CHAR_W-1:0] ch,
                                                      input logic [COL_W-1:0] col,
                                                      input logic [ROW_W-1:0] rw);
        console_request_t req;
        req.op        = op;
        req.char_code = ch;
        req.column    = col;
        req.row       = rw;
        return req;
    endfunction

    // Apply one request to the screen model and return the cursor report.
    function automatic console_result_t predict_console(input console_request_t req);
        console_result_t res;
        int              pos;
        res.cell_value = '0;
        res.scrolled   = 1'b0;
        case (req.op)
            OP_PUT:
            begin
                if (req.char_code == CH_NEWLINE)
                begin
                    cursor_col_model = 0;
                    cursor_row_model++;
                end
                else if (req.char_code == CH_BACKSPACE)
                begin
                    if (cursor_col_model > 0)
                    begin
                        cursor_col_model--;
                        screen_model[cursor_row_model * COLUMNS + cursor_col_model] =
                            {text_attr, CH_SPACE};
                    end
                end
                else
                begin
                    screen_model[cursor_row_model * COLUMNS + cursor_col_model] =
                        {text_attr, req.char_code};
                    cursor_col_model++;
                end
                if (cursor_col_model >= COLUMNS)
                begin
                    cursor_col_model = 0;
                    cursor_row_model++;
                end
                if (cursor_row_model >= ROWS)
                begin
                    for (int i = 0; i < CELLS - COLUMNS; i++)
                        screen_model[i] = screen_model[i + COLUMNS];
                    for (int i = CELLS - COLUMNS; i < CELLS; i++)
                        screen_model[i] = {text_attr, CH_SPACE};
                    cursor_row_model = ROWS - 1;
                    res.scrolled     = 1'b1;
                end
            end
            OP_READ:
            begin
                if (req.column < COLUMNS && req.row < ROWS)
                    res.cell_value = screen_model[req.row * COLUMNS + req.column];
            end
            OP_SET:
            begin
                cursor_col_model = (req.column < COLUMNS) ? int'(req.column) : COLUMNS - 1;
                cursor_row_model = (req.row < ROWS) ? int'(req.row) : ROWS - 1;
            end
            default:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen_model[i] = {text_attr, CH_SPACE};
                cursor_col_model = 0;
                cursor_row_model = 0;
            end
        endcase
        pos          = cursor_row_model * COLUMNS + cursor_col_model;
        res.column   = cursor_col_model[COL_W-1:0];
        res.row      = cursor_row_model[ROW_W-1:0];
        res.position = pos[POS_W-1:0];
        return res;
    endfunction

    // Random request, biased towards the bottom row and the row ends so that
    // wraps and scrolls turn up often.
    function automatic console_request_t random_request();
        console_request_t req;
        int               pick;
        req.op        = OP_PUT;
        req.char_code = CHAR_W'($urandom_range(255));
        req.column    = COL_W'($urandom_range(127));
        req.row       = ROW_W'($urandom_range(31));
        pick          = $urandom_range(99);
        if (pick < 55)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                req.char_code = CH_NEWLINE;
            else if (pick < 18)
                req.char_code = CH_BACKSPACE;
        end
        else if (pick < 78)
        begin
            req.op = OP_READ;
            pick   = $urandom_range(99);
            if (pick < 50)
            begin
                req.row    = ROW_W'(cursor_row_model);
                req.column = COL_W'($urandom_range(COLUMNS - 1));
            end
            else if (pick < 85)
            begin
                req.row    = ROW_W'($urandom_range(ROWS - 1));
                req.column = COL_W'($urandom_range(COLUMNS - 1));
            end
        end
        else if (pick < 98)
        begin
            req.op = OP_SET;
            pick   = $urandom_range(99);
            if (pick < 70)
                req.column = COL_W'($urandom_range(COLUMNS - 1));
            else if (pick < 85)
                req.column = COL_W'($urandom_range(COLUMNS - 1, COLUMNS - 4));
            pick = $urandom_range(99);
            if (pick < 35)
                req.row = ROW_W'(ROWS - 1);
            else if (pick < 80)
                req.row = ROW_W'($urandom_range(ROWS - 1));
        end
        else
        begin
            req.op = OP_CLEAR;
        end
        return req;
    endfunction

    // Send one request; valid is left high on return.
    task automatic send_request(input console_request_t req);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= req.op;
        char_code <= req.char_code;
        column    <= req.column;
        row       <= req.row;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(predict_console(req));
    endtask

    // Drop valid and wait for every outstanding result.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        text_attr = value;
        @(posedge clk);
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Result checker and receiver stall
    always @(posedge clk)
    begin : result_check
        console_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unrequested result: expected none, actual col %0d row %0d",
                         $time, cursor_column, cursor_row);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("cursor_column", 32'(want.column), 32'(cursor_column));
                check_field("cursor_row", 32'(want.row), 32'(cursor_row));
                check_field("cursor_position", 32'(want.position), 32'(cursor_position));
                check_field("cell_data", 32'(want.cell_value), 32'(cell_data));
                check_field("scrolled", 32'(want.scrolled), 32'(scrolled));
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: count cycles in which no channel moves anything
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress in %0d cycles", $time, WATCHDOG_LIMIT);
            $display("text_console_writer_test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic test_reset_screen();
        send_request(make_request(OP_READ, 8'h00, 7'd0, 5'd0));
        send_request(make_request(OP_READ, 8'h00, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1)));
        send_request(make_request(OP_READ, 8'h00, 7'd127, 5'd31));
        send_request(make_request(OP_READ, 8'h00, COL_W'(COLUMNS), 5'd0));
        send_request(make_request(OP_READ, 8'h00, 7'd0, ROW_W'(ROWS)));
        drain_results();
    endtask

    task automatic test_put_characters();
        // backspace at column zero leaves everything alone
        send_request(make_request(OP_PUT, CH_BACKSPACE, 7'd0, 5'd0));
        send_request(make_request(OP_PUT, 8'h41, 7'd0, 5'd0));
        send_request(make_request(OP_PUT, 8'h00, 7'd0, 5'd0));
        send_request(make_request(OP_PUT, 8'hFF, 7'd0, 5'd0));
        send_request(make_request(OP_PUT, CH_BACKSPACE, 7'd0, 5'd0));
        send_request(make_request(OP_READ, 8'h00, 7'd2, 5'd0));
        send_request(make_request(OP_READ, 8'h00, 7'd1, 5'd0));
        send_request(make_request(OP_PUT, CH_NEWLINE, 7'd0, 5'd0));
        drain_results();
    endtask

    task automatic test_wrap_and_scroll();
        send_request(make_request(OP_SET, 8'h00, COL_W'(COLUMNS - 1), 5'd0));
        send_request(make_request(OP_PUT, 8'h78, 7'd0, 5'd0));
        // out-of-screen cursor saturates to the bottom-right cell
        send_request(make_request(OP_SET, 8'h00, 7'd127, 5'd31));
        send_request(make_request(OP_PUT, 8'h79, 7'd0, 5'd0));
        send_request(make_request(OP_READ, 8'h00, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 2)));
        send_request(make_request(OP_SET, 8'h00, 7'd0, ROW_W'(ROWS - 1)));
        send_request(make_request(OP_PUT, CH_NEWLINE, 7'd0, 5'd0));
        drain_results();
    endtask

    task automatic test_clear_and_attribute();
        write_attribute(8'hFF);
        send_request(make_request(OP_CLEAR, 8'h00, 7'd0, 5'd0));
        send_request(make_request(OP_READ, 8'h00, 7'd40, 5'd12));
        drain_results();
        write_attribute(8'h00);
        send_request(make_request(OP_PUT, 8'h7A, 7'd0, 5'd0));
        send_request(make_request(OP_PUT, CH_BACKSPACE, 7'd0, 5'd0));
        send_request(make_request(OP_READ, 8'h00, 7'd0, 5'd0));
        drain_results();
    endtask

    task automatic test_random_traffic(input int items, input int idle, input int stall,
                                       input logic [ATTR_W-1:0] attr);
        write_attribute(attr);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (items)
            send_request(random_request());
        drain_results();
    endtask

    initial
    begin
        for (int i = 0; i < CELLS; i++)
            screen_model[i] = {ATTR_RESET, CH_SPACE};
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_screen();
        test_put_characters();
        test_wrap_and_scroll();
        test_clear_and_attribute();
        test_random_traffic(125, 0, 0, ATTR_W'($urandom_range(255)));
        test_random_traffic(125, 47, 0, ATTR_W'($urandom_range(255)));
        test_random_traffic(125, 0, 47, ATTR_W'($urandom_range(255)));
        test_random_traffic(125, 8, 8, ATTR_W'($urandom_range(255)));

        stall_pct = 0;
        repeat (8)
            @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("text_console_writer_test passed");
        else
            $display("text_console_writer_test failed");
        $finish;
    end

endmodule
